// ----- rtl/tabint_pkg.sv -----
`timescale 1ns / 1ps

package tabint_pkg;

   // default table size
   localparam int TABLE_DEPTH = 64;

   // fixed field widths
   localparam int DATA_W  = 32;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;

   // request codes
   localparam logic REQ_EVALUATE = 1'b0;
   localparam logic REQ_WRITE    = 1'b1;

   // segment form codes
   localparam logic FORM_CONSTANT = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK             = 2'd0;
   localparam logic [1:0] STATUS_FEW_POINTS     = 2'd1;
   localparam logic [1:0] STATUS_NOT_INCREASING = 2'd2;

   typedef struct packed {
      logic                      req_type;
      logic [INDEX_W-1:0]        entry_index;
      logic signed [DATA_W-1:0]  value_x;
      logic signed [DATA_W-1:0]  entry_y;
      logic                      entry_form;
   } tabint_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  result_y;
      logic [1:0]                status;
   } tabint_rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  y;
      logic                      form;
   } tabint_entry_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WR_READ,
      ST_WR_CHECK,
      ST_WRITE,
      ST_EV_LOW,
      ST_EV_LOW_CHK,
      ST_EV_HIGH,
      ST_EV_HIGH_CHK,
      ST_SEARCH,
      ST_SEARCH_CHK,
      ST_FETCH_LO,
      ST_LO_DATA,
      ST_HI_DATA,
      ST_DY,
      ST_DY_ABS,
      ST_MUL,
      ST_DIV,
      ST_FINAL,
      ST_RESP
   } tabint_state_type;

endpackage

// ----- rtl/tabular_interpolator.sv -----
// Piecewise linear table interpolator on signed Q16.16 values.
// Request channel (req_valid / req_stall / req_data): a write request stores
// one breakpoint (x, y, segment form); an evaluate request looks up value_x.
// Response channel (rsp_valid / rsp_stall / rsp_data): one response per
// request, in order, with result_y and a status code.
// csr_wr_en / csr_wr_data set point_count, the number of breakpoints in use;
// write it only while no request is in flight.
// One request is worked on at a time; req_stall is high from acceptance until
// the response has moved into the output register.
// An interior evaluate does one memory read and compare per search probe and
// a bit-serial divide, forming a 32-bit quotient, through the single shared
// adder.
// A new request is taken the cycle after the previous result is registered,
// even while that response is still stalled at the output.
// Reset clears point_count, the sequencer and the output valid; table
// contents are undefined until written.
`timescale 1ns / 1ps

module tabular_interpolator #(
   parameter int TABLE_DEPTH = tabint_pkg::TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tabint_pkg::tabint_req_type         req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tabint_pkg::tabint_rsp_type         rsp_data,
   input  logic                               csr_wr_en,
   input  logic [tabint_pkg::COUNT_W-1:0]     csr_wr_data
);

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int NW  = AW + 1;
   localparam int DW  = tabint_pkg::DATA_W;
   localparam int SW  = DW + 2;
   localparam int QCW = $clog2(DW);

   // control registers
   tabint_pkg::tabint_state_type state_ff, state_in;
   logic [tabint_pkg::COUNT_W-1:0] count_ff;
   logic                           out_valid_ff, out_valid_in;

   // payload registers
   tabint_pkg::tabint_req_type     req_ff, req_in;
   tabint_pkg::tabint_entry_type   rd_ff;
   tabint_pkg::tabint_rsp_type     out_ff, out_in;
   logic [AW-1:0]                  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [DW-1:0]                  x1_ff, x1_in, y1_ff, y1_in, y2_ff, y2_in;
   logic [DW-1:0]                  dx_ff, dx_in, t_ff, t_in, mag_ff, mag_in;
   logic                           neg_ff, neg_in;
   logic [DW-1:0]                  rem_ff, rem_in, low_ff, low_in;
   logic [QCW-1:0]                 cnt_ff, cnt_in;
   logic [DW-1:0]                  res_y_ff, res_y_in;
   logic [1:0]                     res_st_ff, res_st_in;

   // table memory
   tabint_pkg::tabint_entry_type   mem [TABLE_DEPTH];
   logic                           wr_en;
   logic [AW-1:0]                  rd_addr;
   tabint_pkg::tabint_entry_type   wr_entry;

   // shared adder / subtractor
   logic [SW-1:0]                  alu_a, alu_b, alu_res;
   logic                           alu_sub;
   logic                           alu_gt;

   logic [NW-1:0]                  n_val;
   logic                           idx_ok;
   logic [NW-1:0]                  mid_sum;
   logic [2*DW-1:0]                prod;
   logic                           load_out;

   assign alu_res  = alu_a + (alu_sub ? ~alu_b : alu_b) + SW'(alu_sub);
   assign alu_gt   = !alu_res[SW-1] && (alu_res != '0);
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign prod     = (2*DW)'(mag_ff) * (2*DW)'(t_ff);
   assign idx_ok   = 32'(req_data.entry_index) < 32'(TABLE_DEPTH);
   assign wr_entry = '{x: req_ff.value_x, y: req_ff.entry_y, form: req_ff.entry_form};

   // points in use, limited to the table size
   always_comb begin
      if (32'(count_ff) > 32'(TABLE_DEPTH)) begin
         n_val = NW'(TABLE_DEPTH);
      end else begin
         n_val = NW'(count_ff);
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      x1_in     = x1_ff;
      y1_in     = y1_ff;
      y2_in     = y2_ff;
      dx_in     = dx_ff;
      t_in      = t_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      rem_in    = rem_ff;
      low_in    = low_ff;
      cnt_in    = cnt_ff;
      res_y_in  = res_y_ff;
      res_st_in = res_st_ff;
      alu_a     = {{(SW-DW){req_ff.value_x[DW-1]}}, req_ff.value_x};
      alu_b     = {{(SW-DW){rd_ff.x[DW-1]}}, rd_ff.x};
      alu_sub   = 1'b1;
      rd_addr   = lo_ff;
      wr_en     = 1'b0;
      load_out  = 1'b0;
      req_stall = 1'b1;

      unique case (state_ff)
         tabint_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in    = req_data;
               res_y_in  = '0;
               res_st_in = tabint_pkg::STATUS_OK;
               unique case (req_data.req_type)
                  tabint_pkg::REQ_WRITE: begin
                     if (!idx_ok) begin
                        state_in = tabint_pkg::ST_RESP;
                     end else if (req_data.entry_index == '0) begin
                        state_in = tabint_pkg::ST_WRITE;
                     end else begin
                        state_in = tabint_pkg::ST_WR_READ;
                     end
                  end
                  tabint_pkg::REQ_EVALUATE: begin
                     if (n_val < NW'(2)) begin
                        res_st_in = tabint_pkg::STATUS_FEW_POINTS;
                        state_in  = tabint_pkg::ST_RESP;
                     end else begin
                        lo_in    = '0;
                        hi_in    = AW'(n_val - NW'(1));
                        state_in = tabint_pkg::ST_EV_LOW;
                     end
                  end
                  default: state_in = tabint_pkg::ST_IDLE;
               endcase
            end
         end
         // previous entry for the increasing-x check
         tabint_pkg::ST_WR_READ: begin
            rd_addr  = AW'(req_ff.entry_index) - AW'(1);
            state_in = tabint_pkg::ST_WR_CHECK;
         end
         tabint_pkg::ST_WR_CHECK: begin
            if (!alu_gt) begin
               res_st_in = tabint_pkg::STATUS_NOT_INCREASING;
               state_in  = tabint_pkg::ST_RESP;
            end else begin
               state_in = tabint_pkg::ST_WRITE;
            end
         end
         tabint_pkg::ST_WRITE: begin
            wr_en    = 1'b1;
            state_in = tabint_pkg::ST_RESP;
         end
         // clamp below the first point
         tabint_pkg::ST_EV_LOW: begin
            rd_addr  = '0;
            state_in = tabint_pkg::ST_EV_LOW_CHK;
         end
         tabint_pkg::ST_EV_LOW_CHK: begin
            if (!alu_gt) begin
               res_y_in = rd_ff.y;
               state_in = tabint_pkg::ST_RESP;
            end else begin
               state_in = tabint_pkg::ST_EV_HIGH;
            end
         end
         // clamp above the last point
         tabint_pkg::ST_EV_HIGH: begin
            rd_addr  = hi_ff;
            state_in = tabint_pkg::ST_EV_HIGH_CHK;
         end
         tabint_pkg::ST_EV_HIGH_CHK: begin
            if (alu_gt) begin
               res_y_in = rd_ff.y;
               state_in = tabint_pkg::ST_RESP;
            end else if ((hi_ff - lo_ff) > AW'(1)) begin
               state_in = tabint_pkg::ST_SEARCH;
            end else begin
               state_in = tabint_pkg::ST_FETCH_LO;
            end
         end
         // binary search probe
         tabint_pkg::ST_SEARCH: begin
            mid_in   = mid_sum[NW-1:1];
            rd_addr  = mid_sum[NW-1:1];
            state_in = tabint_pkg::ST_SEARCH_CHK;
         end
         tabint_pkg::ST_SEARCH_CHK: begin
            if (alu_gt) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff;
            end
            if ((hi_in - lo_in) > AW'(1)) begin
               state_in = tabint_pkg::ST_SEARCH;
            end else begin
               state_in = tabint_pkg::ST_FETCH_LO;
            end
         end
         tabint_pkg::ST_FETCH_LO: begin
            rd_addr  = lo_ff;
            state_in = tabint_pkg::ST_LO_DATA;
         end
         // left point: t = xv - x1
         tabint_pkg::ST_LO_DATA: begin
            rd_addr = hi_ff;
            x1_in   = rd_ff.x;
            y1_in   = rd_ff.y;
            t_in    = alu_res[DW-1:0];
            if (rd_ff.form == tabint_pkg::FORM_CONSTANT) begin
               res_y_in = rd_ff.y;
               state_in = tabint_pkg::ST_RESP;
            end else begin
               state_in = tabint_pkg::ST_HI_DATA;
            end
         end
         // right point: dx = x2 - x1
         tabint_pkg::ST_HI_DATA: begin
            alu_a    = {{(SW-DW){rd_ff.x[DW-1]}}, rd_ff.x};
            alu_b    = {{(SW-DW){x1_ff[DW-1]}}, x1_ff};
            dx_in    = alu_res[DW-1:0];
            y2_in    = rd_ff.y;
            state_in = tabint_pkg::ST_DY;
         end
         // dy = y2 - y1 and its sign
         tabint_pkg::ST_DY: begin
            alu_a  = {{(SW-DW){y2_ff[DW-1]}}, y2_ff};
            alu_b  = {{(SW-DW){y1_ff[DW-1]}}, y1_ff};
            neg_in = alu_res[SW-1];
            mag_in = alu_res[DW-1:0];
            if (alu_res[SW-1]) begin
               state_in = tabint_pkg::ST_DY_ABS;
            end else begin
               state_in = tabint_pkg::ST_MUL;
            end
         end
         tabint_pkg::ST_DY_ABS: begin
            alu_a    = {{(SW-DW){y1_ff[DW-1]}}, y1_ff};
            alu_b    = {{(SW-DW){y2_ff[DW-1]}}, y2_ff};
            mag_in   = alu_res[DW-1:0];
            state_in = tabint_pkg::ST_MUL;
         end
         // |dy| * t, high half seeds the divide remainder
         tabint_pkg::ST_MUL: begin
            rem_in   = prod[2*DW-1:DW];
            low_in   = prod[DW-1:0];
            cnt_in   = '0;
            state_in = tabint_pkg::ST_DIV;
         end
         // restoring divide, one quotient bit per cycle
         tabint_pkg::ST_DIV: begin
            alu_a = {1'b0, rem_ff, low_ff[DW-1]};
            alu_b = {2'b00, dx_ff};
            if (!alu_res[SW-1]) begin
               rem_in = alu_res[DW-1:0];
            end else begin
               rem_in = {rem_ff[DW-2:0], low_ff[DW-1]};
            end
            low_in = {low_ff[DW-2:0], !alu_res[SW-1]};
            cnt_in = cnt_ff + QCW'(1);
            if (cnt_ff == '1) begin
               state_in = tabint_pkg::ST_FINAL;
            end
         end
         // y1 plus or minus the quotient
         tabint_pkg::ST_FINAL: begin
            alu_a    = {{(SW-DW){y1_ff[DW-1]}}, y1_ff};
            alu_b    = {2'b00, low_ff};
            alu_sub  = neg_ff;
            res_y_in = alu_res[DW-1:0];
            state_in = tabint_pkg::ST_RESP;
         end
         // hand the result to the output register
         tabint_pkg::ST_RESP: begin
            if (!out_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = tabint_pkg::ST_IDLE;
            end
         end
         default: state_in = tabint_pkg::ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      out_valid_in = load_out || (out_valid_ff && rsp_stall);
      if (load_out) begin
         out_in = '{result_y: res_y_ff, status: res_st_ff};
      end else begin
         out_in = out_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tabint_pkg::ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      x1_ff     <= x1_in;
      y1_ff     <= y1_in;
      y2_ff     <= y2_in;
      dx_ff     <= dx_in;
      t_ff      <= t_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      rem_ff    <= rem_in;
      low_ff    <= low_in;
      cnt_ff    <= cnt_in;
      res_y_ff  <= res_y_in;
      res_st_ff <= res_st_in;
      out_ff    <= out_in;
   end

   // breakpoint table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(req_ff.entry_index)] <= wr_entry;
      end
      rd_ff <= mem[rd_addr];
   end

endmodule

// ----- rtl/tabint_checker.sv -----
`timescale 1ns / 1ps

module tabint_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input tabint_pkg::tabint_req_type         req_data,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input tabint_pkg::tabint_rsp_type         rsp_data,
   input logic                               csr_wr_en,
   input logic [tabint_pkg::COUNT_W-1:0]     csr_wr_data
);

   // stalled response holds
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // error responses carry zero
   rsp_zero_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != tabint_pkg::STATUS_OK |-> rsp_data.result_y == '0)
      else $error("non-ok response with nonzero result");

   // only defined status codes
   rsp_status_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == tabint_pkg::STATUS_OK ||
                    rsp_data.status == tabint_pkg::STATUS_FEW_POINTS ||
                    rsp_data.status == tabint_pkg::STATUS_NOT_INCREASING)
      else $error("undefined status code");

   // busy after taking a request
   req_busy_a: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

endmodule

bind tabular_interpolator tabint_checker u_tabint_checker (.*);

// ----- sim/tabular_interpolator_test.sv -----
`timescale 1ns / 1ps

module tabular_interpolator_test;
   import tabint_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 80;

   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic FORM_LINEAR = ~FORM_CONSTANT;
   localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

   // shadow table, point count and the responses still owed by the block
   class lookup_checker;
      logic signed [DATA_W-1:0] bp_x [TABLE_DEPTH];
      logic signed [DATA_W-1:0] bp_y [TABLE_DEPTH];
      logic                     bp_form [TABLE_DEPTH];
      logic [COUNT_W-1:0]       point_count;
      tabint_rsp_type           awaited [$];
      int errors;
      int writes;
      int rejected;
      int evaluates;
      int few_points;

      function new();
         int i;
         for (i = 0; i < TABLE_DEPTH; i++) begin
            bp_x[i] = '0;
            bp_y[i] = '0;
            bp_form[i] = 1'b0;
         end
         point_count = '0;
         errors = 0;
         writes = 0;
         rejected = 0;
         evaluates = 0;
         few_points = 0;
      endfunction

      // y1 + trunc(|dy| * (xv - x1) / (x2 - x1)) with the sign of dy
      function logic signed [DATA_W-1:0] segment_value(logic signed [DATA_W-1:0] xv,
                                                       int a, int b);
         longint x1, x2, y1, y2, dy, r;
         logic [63:0] mag, t, dx, q;
         x1 = bp_x[a];
         x2 = bp_x[b];
         y1 = bp_y[a];
         y2 = bp_y[b];
         dy = y2 - y1;
         mag = (dy < 0) ? -dy : dy;
         t = longint'(xv) - x1;
         dx = x2 - x1;
         if (dx == 0) return bp_y[a];
         q = (mag * t) / dx;
         r = (dy < 0) ? y1 - longint'(q) : y1 + longint'(q);
         return r[DATA_W-1:0];
      endfunction

      // clamp at the ends, else left-continuous binary search
      function logic signed [DATA_W-1:0] table_value(logic signed [DATA_W-1:0] xv, int n);
         int lo, hi, mid;
         lo = 0;
         hi = n - 1;
         if (xv <= bp_x[0]) return bp_y[0];
         if (xv > bp_x[n-1]) return bp_y[n-1];
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (xv > bp_x[mid]) lo = mid;
            else hi = mid;
         end
         if (bp_form[lo] == FORM_CONSTANT) return bp_y[lo];
         return segment_value(xv, lo, hi);
      endfunction

      function tabint_rsp_type lookup_result(tabint_req_type r);
         tabint_rsp_type o;
         int n, idx;
         o.result_y = '0;
         o.status = STATUS_OK;
         idx = r.entry_index;
         if (r.req_type == REQ_WRITE) begin
            writes++;
            if (idx < TABLE_DEPTH) begin
               if (idx > 0 && r.value_x <= bp_x[idx-1]) begin
                  o.status = STATUS_NOT_INCREASING;
                  rejected++;
               end else begin
                  bp_x[idx] = r.value_x;
                  bp_y[idx] = r.entry_y;
                  bp_form[idx] = r.entry_form;
               end
            end
         end else begin
            evaluates++;
            n = (point_count > TABLE_DEPTH) ? TABLE_DEPTH : point_count;
            if (n < 2) begin
               o.status = STATUS_FEW_POINTS;
               few_points++;
            end else begin
               o.result_y = table_value(r.value_x, n);
            end
         end
         return o;
      endfunction

      function void note_request(tabint_req_type r);
         awaited.push_back(lookup_result(r));
      endfunction

      function void check_response(tabint_rsp_type got);
         tabint_rsp_type want;
         if (awaited.size() == 0) begin
            $error("response with no request waiting: result_y %0d, status %0d",
                   got.result_y, got.status);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.result_y !== want.result_y) begin
            $error("result_y mismatch: expected %0d, actual %0d", want.result_y, got.result_y);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   tabint_req_type      req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   tabint_rsp_type      rsp_data;
   logic                csr_wr_en;
   logic [COUNT_W-1:0]  csr_wr_data;

   lookup_checker lookup;
   int send_idle_pct;
   int recv_idle_pct;
   int filled;          // entries 0..filled-1 have been written
   int sent_items;
   int settings;
   int hold_requests;
   int holds_taken;
   int hold_left;

   tabular_interpolator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // offer one request, with random idle cycles ahead of it
   task automatic send_request(input tabint_req_type item);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      lookup.note_request(item);
      sent_items++;
   endtask

   task automatic write_entry(input int idx, input logic signed [DATA_W-1:0] x,
                              input logic signed [DATA_W-1:0] y, input logic form);
      tabint_req_type item;
      item.req_type    = REQ_WRITE;
      item.entry_index = INDEX_W'(idx);
      item.value_x     = x;
      item.entry_y     = y;
      item.entry_form  = form;
      send_request(item);
   endtask

   task automatic evaluate_at(input logic signed [DATA_W-1:0] x);
      tabint_req_type item;
      item.req_type    = REQ_EVALUATE;
      item.entry_index = INDEX_W'($urandom);
      item.value_x     = x;
      item.entry_y     = $urandom;
      item.entry_form  = 1'($urandom);
      send_request(item);
   endtask

   // stop offering and wait for every owed response
   task automatic drain_requests();
      req_valid <= 1'b0;
      while (lookup.pending() != 0) @(posedge clock);
   endtask

   task automatic set_point_count(input logic [COUNT_W-1:0] value);
      drain_requests();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      lookup.point_count = value;
      settings++;
   endtask

   // write entries 0..k-1 with strictly increasing x
   task automatic build_table(input int k);
      longint base, room, cap, scale, xcur;
      int i, r;
      bit small_y;
      logic signed [DATA_W-1:0] y;
      r = $urandom;
      base = r;
      if ($urandom_range(0, 7) == 0) base = longint'(Q_MIN);
      room = longint'(Q_MAX) - base;
      if (room < 4 * k) begin
         base = longint'(Q_MIN);
         room = longint'(Q_MAX) - base;
      end
      cap = room / k;
      scale = longint'(1) << $urandom_range(0, 31);
      if (scale < cap) cap = scale;
      small_y = ($urandom_range(0, 2) == 0);
      xcur = base;
      for (i = 0; i < k; i++) begin
         if (i > 0) xcur = xcur + longint'($urandom_range(1, 32'(cap)));
         y = small_y ? DATA_W'($urandom_range(0, 4000) - 2000) : DATA_W'($urandom);
         write_entry(i, xcur[DATA_W-1:0], y,
                     ($urandom_range(0, 99) < 30) ? FORM_CONSTANT : FORM_LINEAR);
      end
      if (k > filled) filled = k;
   endtask

   // query point: breakpoints, their neighbours, inside the span or anywhere
   function automatic logic signed [DATA_W-1:0] pick_query_x(input int n);
      longint lo_x, hi_x, pos;
      logic [63:0] span, rnd, off;
      int j;
      if (n < 2) return $urandom;
      j = $urandom_range(0, n - 1);
      lo_x = lookup.bp_x[0];
      hi_x = lookup.bp_x[n-1];
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return lookup.bp_x[j];
         2: return lookup.bp_x[j] + 1;
         3: return lookup.bp_x[j] - 1;
         default: begin
            if (hi_x <= lo_x) return lookup.bp_x[j];
            span = hi_x - lo_x;
            rnd = {$urandom, $urandom};
            off = rnd % (span + 64'd1);
            pos = lo_x + longint'(off);
            return pos[DATA_W-1:0];
         end
      endcase
   endfunction

   // overwrite a written entry; often with an x that must be rejected
   task automatic disturb_table();
      int idx;
      logic signed [DATA_W-1:0] x;
      idx = $urandom_range(0, filled - 1);
      case ($urandom_range(0, 2))
         0: x = (idx > 0) ? lookup.bp_x[idx-1] : DATA_W'($urandom);
         1: x = (idx > 0) ? lookup.bp_x[idx-1] - DATA_W'($urandom_range(1, 100000))
                          : DATA_W'($urandom);
         default: x = $urandom;
      endcase
      write_entry(idx, x, $urandom, 1'($urandom));
   endtask

   // response side: check accepted responses, drive stall
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) lookup.check_response(rsp_data);
      if (hold_requests != holds_taken) begin
         hold_left = HOLD_CYCLES;
         holds_taken++;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // watchdog on cycles in which nothing moves
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      int k, p, n, start, done, session;
      lookup = new();
      filled = 0;
      sent_items = 0;
      settings = 0;
      hold_requests = 0;
      holds_taken = 0;
      hold_left = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      rsp_stall   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      set_idle(24, 54);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // too few points: empty table, then a single point
      set_point_count(0);
      evaluate_at(32'sd0);
      set_point_count(1);
      evaluate_at($urandom);

      // three points spanning the whole range, extreme ordinates
      write_entry(0, Q_MIN, Q_MAX, FORM_LINEAR);
      write_entry(1, 32'sd0, Q_MIN, FORM_LINEAR);
      write_entry(2, Q_MAX, Q_MAX, FORM_LINEAR);
      // rejected writes: equal x twice, smaller x once
      write_entry(1, Q_MIN, 32'sd7, FORM_CONSTANT);
      write_entry(2, 32'sd0, 32'sd7, FORM_CONSTANT);
      write_entry(2, -32'sd5, 32'sd7, FORM_CONSTANT);
      // the first entry is never rejected
      write_entry(0, Q_MIN, Q_MAX, FORM_LINEAR);
      filled = 3;

      set_point_count(3);
      evaluate_at(Q_MIN);
      evaluate_at(Q_MIN + 32'sd1);
      evaluate_at(32'sd0);
      evaluate_at(32'sd1);
      evaluate_at(Q_MAX);
      // constant segment from the middle entry
      write_entry(1, 32'sd0, Q_MIN, FORM_CONSTANT);
      evaluate_at(32'sd1);
      evaluate_at(-32'sd1);
      // clamp above the last point
      set_point_count(2);
      evaluate_at(32'sd1);
      evaluate_at(Q_MAX);

      // random part: build a table, pick a count, then query it
      session = 0;
      start = sent_items;
      while (sent_items - start < RANDOM_ITEMS) begin
         done = sent_items - start;
         if (done < RANDOM_ITEMS / 3) set_idle(24, 54);
         else if (done < 2 * RANDOM_ITEMS / 3) set_idle(54, 24);
         else set_idle(0, 0);

         if (session == 0) k = TABLE_DEPTH;
         else if ($urandom_range(0, 3) == 0) k = $urandom_range(2, TABLE_DEPTH);
         else k = $urandom_range(2, 12);
         build_table(k);

         if (session == 0) p = COUNT_TOP;
         else if (session == 1) p = TABLE_DEPTH;
         else begin
            case ($urandom_range(0, 9))
               0: p = $urandom_range(0, 1);
               1: p = (filled == TABLE_DEPTH) ? $urandom_range(TABLE_DEPTH + 1, COUNT_TOP)
                                              : filled;
               2: p = $urandom_range(k, filled);
               default: p = k;
            endcase
         end
         set_point_count(p);
         n = (p > TABLE_DEPTH) ? TABLE_DEPTH : p;

         // long output hold while requests keep coming
         if (session == 3) hold_requests++;
         repeat ($urandom_range(8, 30)) begin
            if ($urandom_range(0, 9) == 0) disturb_table();
            else evaluate_at(pick_query_x(n));
         end
         session++;
      end

      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d writes (%0d rejected), %0d evaluates (%0d with too few points)",
               lookup.writes, lookup.rejected, lookup.evaluates, lookup.few_points);
      $display("over %0d table builds and %0d point count settings, one %0d-cycle output hold",
               session, settings, HOLD_CYCLES);
      if (lookup.errors == 0 && lookup.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
